FILE: sv/ubds_pkg.sv
`timescale 1ns / 1ps

package ubds_pkg;

  // Field and datapath widths fixed by the interface.
  localparam int BAUD_W      = 24;
  localparam int CLK_W       = 32;
  localparam int OSR_W       = 6;
  localparam int OSR_FIELD_W = 5;
  localparam int DIV_FIELD_W = 13;

  // baud * ratio, with the ratio at most 32.
  localparam int BR_W  = BAUD_W + OSR_W;
  // Divider denominator 2 * baud * ratio.
  localparam int DEN_W = BR_W + 1;
  // Divider numerator 2 * clock + baud * ratio.
  localparam int NUM_W = CLK_W + 2;

  localparam logic [CLK_W-1:0] CLK_RESET       = 32'd24000000;
  localparam logic [OSR_W-1:0] MIN_OVERSAMPLE  = 6'd4;
  localparam logic [OSR_W-1:0] BOTH_EDGE_LIMIT = 6'd8;

  typedef enum logic [1:0] {
    KIND_NORMAL    = 2'd0,
    KIND_ZERO_BAUD = 2'd1,
    KIND_ZERO_CLK  = 2'd2
  } job_kind_t;

  typedef struct packed {
    logic [BAUD_W-1:0] baud;
    logic [CLK_W-1:0]  clk_hz;
    job_kind_t         kind;
  } job_t;

  typedef struct packed {
    logic [OSR_FIELD_W-1:0] oversample_minus_one;
    logic [DIV_FIELD_W-1:0] divisor;
    logic                   both_edge;
  } result_t;

endpackage

FILE: sv/ubds_ifs.sv
`timescale 1ns / 1ps

interface ubds_in_if;
  logic                       valid;
  logic                       ready;
  logic [ubds_pkg::BAUD_W-1:0] baud_rate;

  modport source(output valid, output baud_rate, input ready);
  modport sink(input valid, input baud_rate, output ready);
endinterface

interface ubds_out_if;
  logic                            valid;
  logic                            ready;
  logic [ubds_pkg::OSR_FIELD_W-1:0] oversample_minus_one;
  logic [ubds_pkg::DIV_FIELD_W-1:0] divisor;
  logic                            both_edge;

  modport source(output valid, output oversample_minus_one, output divisor,
                 output both_edge, input ready);
  modport sink(input valid, input oversample_minus_one, input divisor,
               input both_edge, output ready);
endinterface

interface ubds_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ubds_pkg::CLK_W-1:0] source_clock_hz;

  modport source(output valid, output source_clock_hz, input ready);
  modport sink(input valid, input source_clock_hz, output ready);
endinterface

FILE: sv/uart_baud_divisor_search.sv
`timescale 1ns / 1ps

// Baud divisor search. Each transfer on the input channel carries a requested
// bit rate; the block tries every oversampling ratio from 4 to MAX_OVERSAMPLE,
// forms the rounded divisor clock / (rate * ratio) clamped to 1..MAX_DIVISOR,
// scores each pair by the exact error |divisor * ratio * rate - clock| and
// returns one result per request: the winning ratio minus one, the divisor
// (low 13 bits) and a both-edge flag for ratios of 8 or less. Ties go to the
// larger ratio. The source clock comes from the configuration channel, which
// is always ready and resets to 24 MHz; write it only while no request is in
// flight. The search uses a shared restoring divider in the back end, which
// retires one quotient bit per cycle and is used at most once per ratio. A
// ratio whose quotient would not fit in the divider's quotient register skips
// the divider and goes from the saturation check straight to the product. A
// zero rate or a zero clock is recognized on entry and goes straight to the
// result stage. A two-entry queue decouples request intake from the search,
// and an output register holds a finished result so the next search can
// start while the result waits to be taken.
module uart_baud_divisor_search #(
  parameter int MAX_DIVISOR    = 8191,
  parameter int MAX_OVERSAMPLE = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  ubds_in_if.sink     in_chan,
  ubds_cfg_if.sink    cfg_chan,
  ubds_out_if.source  out_chan
);

  logic [ubds_pkg::CLK_W-1:0] source_clock_r;
  logic                       job_valid;
  logic                       job_take;
  ubds_pkg::job_t             job;

  // Every configuration transfer is taken at once.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_clock_r <= ubds_pkg::CLK_RESET;
    end else if (cfg_chan.valid) begin
      source_clock_r <= cfg_chan.source_clock_hz;
    end
  end

  // Front end: accepts requests, tags the degenerate cases and queues them
  // together with the clock setting in force.
  ubds_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .clk_hz    (source_clock_r),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take)
  );

  // Back end: sequential search over the ratios and the result register.
  ubds_back #(
    .MAX_DIVISOR    (MAX_DIVISOR),
    .MAX_OVERSAMPLE (MAX_OVERSAMPLE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .out_chan  (out_chan)
  );

endmodule

FILE: sv/ubds_front.sv
`timescale 1ns / 1ps

module ubds_front (
  input  logic                       clk,
  input  logic                       rst_n,
  ubds_in_if.sink                    in_chan,
  input  logic [ubds_pkg::CLK_W-1:0] clk_hz,
  output logic                       job_valid,
  output ubds_pkg::job_t             job,
  input  logic                       job_take
);

  ubds_pkg::job_t q_r [2];
  logic           wr_ptr_r;
  logic           wr_ptr_nxt;
  logic           rd_ptr_r;
  logic           rd_ptr_nxt;
  logic [1:0]     count_r;
  logic [1:0]     count_nxt;
  logic           push;
  logic           pop;
  ubds_pkg::job_t new_job;

  assign in_chan.ready = (count_r != 2'd2);
  assign push          = in_chan.valid && in_chan.ready;
  assign job_valid     = (count_r != 2'd0);
  assign pop           = job_valid && job_take;
  assign job           = q_r[rd_ptr_r];

  // A zero rate saturates every quotient, which outranks a zero clock.
  always_comb begin
    new_job.baud   = in_chan.baud_rate;
    new_job.clk_hz = clk_hz;
    priority if (in_chan.baud_rate == '0) begin
      new_job.kind = ubds_pkg::KIND_ZERO_BAUD;
    end else if (clk_hz == '0) begin
      new_job.kind = ubds_pkg::KIND_ZERO_CLK;
    end else begin
      new_job.kind = ubds_pkg::KIND_NORMAL;
    end
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_job;
    end
  end

endmodule

FILE: sv/ubds_back.sv
`timescale 1ns / 1ps

module ubds_back #(
  parameter int MAX_DIVISOR    = 8191,
  parameter int MAX_OVERSAMPLE = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  input  ubds_pkg::job_t job,
  output logic           job_take,
  ubds_out_if.source     out_chan
);

  localparam int DIV_W  = $clog2(MAX_DIVISOR + 1);
  localparam int CNT_W  = $clog2(DIV_W);
  localparam int SHF_W  = ubds_pkg::DEN_W + DIV_W - 1;
  localparam int SAT_W  = ubds_pkg::DEN_W + DIV_W;
  localparam int PROD_W = DIV_W + ubds_pkg::BR_W;

  localparam logic [DIV_W-1:0]           MAX_D = DIV_W'(MAX_DIVISOR);
  localparam logic [ubds_pkg::OSR_W-1:0] MAX_R = ubds_pkg::OSR_W'(MAX_OVERSAMPLE);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SAT  = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_PROD = 6'b001000,
    ST_CMP  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t                          state_r;
  state_t                          state_nxt;
  logic [ubds_pkg::BAUD_W-1:0]     baud_r;
  logic [ubds_pkg::CLK_W-1:0]      clk_r;
  logic [ubds_pkg::OSR_W-1:0]      osr_r;
  logic [ubds_pkg::BR_W-1:0]       br_r;
  logic                            sat_r;
  logic [ubds_pkg::NUM_W-1:0]      rem_r;
  logic [SHF_W-1:0]                den_sh_r;
  logic [DIV_W-1:0]                q_r;
  logic [CNT_W-1:0]                cnt_r;
  logic [PROD_W-1:0]               prod_r;
  logic [DIV_W-1:0]                d_r;
  logic [PROD_W-1:0]               best_err_r;
  logic [DIV_W-1:0]                best_div_r;
  logic [ubds_pkg::OSR_W-1:0]      best_osr_r;
  logic                            out_valid_r;
  logic                            out_valid_nxt;
  ubds_pkg::result_t               out_r;

  logic [ubds_pkg::NUM_W-1:0]      num;
  logic [ubds_pkg::DEN_W-1:0]      den;
  logic                            sat_hit;
  logic                            div_ge;
  logic [ubds_pkg::NUM_W-1:0]      rem_sub;
  logic [DIV_W-1:0]                d_sel;
  logic [PROD_W-1:0]               prod_nxt;
  logic [PROD_W-1:0]               clk_ext;
  logic [PROD_W-1:0]               err;
  logic                            take_cand;
  logic                            out_load;

  assign job_take = (state_r == ST_IDLE);

  // Rounded quotient: floor((2*clk + br) / (2*br)).
  assign num     = {1'b0, clk_r, 1'b0} + ubds_pkg::NUM_W'(br_r);
  assign den     = {br_r, 1'b0};
  assign sat_hit = SAT_W'(num) >= {den, {DIV_W{1'b0}}};
  assign div_ge  = SHF_W'(rem_r) >= den_sh_r;
  assign rem_sub = rem_r - ubds_pkg::NUM_W'(den_sh_r);

  always_comb begin
    priority if (sat_r || (q_r > MAX_D)) begin
      d_sel = MAX_D;
    end else if (q_r == '0) begin
      d_sel = DIV_W'(1);
    end else begin
      d_sel = q_r;
    end
  end

  assign prod_nxt  = d_sel * br_r;
  assign clk_ext   = PROD_W'(clk_r);
  assign err       = (prod_r >= clk_ext) ? (prod_r - clk_ext) : (clk_ext - prod_r);
  // The first ratio always seeds the best pair; later ties go to the larger ratio.
  assign take_cand = (osr_r == ubds_pkg::MIN_OVERSAMPLE) || (err <= best_err_r);
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          state_nxt = (job.kind == ubds_pkg::KIND_NORMAL) ? ST_SAT : ST_DONE;
        end
      end
      ST_SAT:  state_nxt = sat_hit ? ST_PROD : ST_DIV;
      ST_DIV:  state_nxt = (cnt_r == '0) ? ST_PROD : ST_DIV;
      ST_PROD: state_nxt = ST_CMP;
      ST_CMP:  state_nxt = (osr_r == MAX_R) ? ST_DONE : ST_SAT;
      ST_DONE: state_nxt = out_load ? ST_IDLE : ST_DONE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          baud_r <= job.baud;
          clk_r  <= job.clk_hz;
          osr_r  <= ubds_pkg::MIN_OVERSAMPLE;
          br_r   <= {{(ubds_pkg::OSR_W - 2){1'b0}}, job.baud, 2'b00};
          unique case (job.kind)
            ubds_pkg::KIND_ZERO_BAUD: begin
              best_osr_r <= MAX_R;
              best_div_r <= MAX_D;
            end
            ubds_pkg::KIND_ZERO_CLK: begin
              best_osr_r <= ubds_pkg::MIN_OVERSAMPLE;
              best_div_r <= DIV_W'(1);
            end
            default: begin
              best_osr_r <= best_osr_r;
              best_div_r <= best_div_r;
            end
          endcase
        end
      end
      ST_SAT: begin
        sat_r    <= sat_hit;
        rem_r    <= num;
        den_sh_r <= {den, {(DIV_W - 1){1'b0}}};
        q_r      <= '0;
        cnt_r    <= CNT_W'(DIV_W - 1);
      end
      ST_DIV: begin
        if (div_ge) begin
          rem_r <= rem_sub;
        end
        q_r      <= {q_r[DIV_W-2:0], div_ge};
        den_sh_r <= den_sh_r >> 1;
        cnt_r    <= cnt_r - CNT_W'(1);
      end
      ST_PROD: begin
        d_r    <= d_sel;
        prod_r <= prod_nxt;
      end
      ST_CMP: begin
        if (take_cand) begin
          best_err_r <= err;
          best_div_r <= d_r;
          best_osr_r <= osr_r;
        end
        osr_r <= osr_r + ubds_pkg::OSR_W'(1);
        br_r  <= br_r + ubds_pkg::BR_W'(baud_r);
      end
      ST_DONE: begin
        if (out_load) begin
          out_r.oversample_minus_one <=
            ubds_pkg::OSR_FIELD_W'(best_osr_r - ubds_pkg::OSR_W'(1));
          out_r.divisor   <= ubds_pkg::DIV_FIELD_W'(best_div_r);
          out_r.both_edge <= (best_osr_r <= ubds_pkg::BOTH_EDGE_LIMIT);
        end
      end
      default: begin
        out_r <= out_r;
      end
    endcase
  end

  assign out_chan.valid                = out_valid_r;
  assign out_chan.oversample_minus_one = out_r.oversample_minus_one;
  assign out_chan.divisor              = out_r.divisor;
  assign out_chan.both_edge            = out_r.both_edge;

  // The scored divisor is always inside the clamp range.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> ((d_r != '0) && (d_r <= MAX_D)))
    else $error("scored divisor outside clamp range");

  // Restoring division invariant: the partial remainder stays below twice the shifted divisor.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> ((SHF_W + 1)'(rem_r) < {den_sh_r, 1'b0}))
    else $error("divider remainder out of range");

  // The ratio under test stays within the searched range.
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SAT) || (state_r == ST_DIV) || (state_r == ST_PROD) ||
     (state_r == ST_CMP)) |-> ((osr_r >= ubds_pkg::MIN_OVERSAMPLE) && (osr_r <= MAX_R)))
    else $error("oversampling ratio out of range");

  // A result appears only after the back end has reached its result state.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result presented without a finished search");

endmodule
